@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition checked at every edge outside reset.
`define ZS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define ZS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent, reset included.
`define ZS_ASSERT_NEXT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/zspwd_pkg.sv @@
// Package with types, codes and the drain remap table of the pixel word decoder.
package zspwd_pkg;

    typedef logic [15:0] t_word;
    typedef logic [10:0] t_row_limit;
    typedef logic [9:0]  t_row;
    typedef logic [5:0]  t_col;
    typedef logic [7:0]  t_value;
    typedef logic [5:0]  t_cm;
    typedef logic [7:0]  t_gate;
    typedef logic [7:0]  t_drain;

    localparam t_word      SUBFRAME_WORD   = 16'hA000;
    localparam t_row_limit ROW_LIMIT_RESET = 11'd960;

    localparam t_drain DRAIN_MAP [256] = '{
        8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
        8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,
        8'd16,  8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,
        8'd24,  8'd25,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,
        8'd32,  8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,
        8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
        8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,
        8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,
        8'd64,  8'd68,  8'd72,  8'd76,  8'd80,  8'd84,  8'd88,  8'd92,
        8'd100, 8'd99,  8'd101, 8'd98,  8'd102, 8'd97,  8'd103, 8'd96,
        8'd65,  8'd69,  8'd73,  8'd77,  8'd81,  8'd85,  8'd89,  8'd93,
        8'd108, 8'd107, 8'd109, 8'd106, 8'd110, 8'd105, 8'd111, 8'd104,
        8'd66,  8'd70,  8'd74,  8'd78,  8'd82,  8'd86,  8'd90,  8'd94,
        8'd116, 8'd115, 8'd117, 8'd114, 8'd118, 8'd113, 8'd119, 8'd112,
        8'd67,  8'd71,  8'd75,  8'd79,  8'd83,  8'd87,  8'd91,  8'd95,
        8'd124, 8'd123, 8'd125, 8'd122, 8'd126, 8'd121, 8'd127, 8'd120,
        8'd188, 8'd184, 8'd180, 8'd176, 8'd172, 8'd168, 8'd164, 8'd160,
        8'd132, 8'd131, 8'd133, 8'd130, 8'd134, 8'd129, 8'd135, 8'd128,
        8'd189, 8'd185, 8'd181, 8'd177, 8'd173, 8'd169, 8'd165, 8'd161,
        8'd140, 8'd139, 8'd141, 8'd138, 8'd142, 8'd137, 8'd143, 8'd136,
        8'd190, 8'd186, 8'd182, 8'd178, 8'd174, 8'd170, 8'd166, 8'd162,
        8'd148, 8'd147, 8'd149, 8'd146, 8'd150, 8'd145, 8'd151, 8'd144,
        8'd191, 8'd187, 8'd183, 8'd179, 8'd175, 8'd171, 8'd167, 8'd163,
        8'd156, 8'd155, 8'd157, 8'd154, 8'd158, 8'd153, 8'd159, 8'd152,
        8'd192, 8'd193, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199,
        8'd200, 8'd201, 8'd202, 8'd203, 8'd204, 8'd205, 8'd206, 8'd207,
        8'd208, 8'd209, 8'd210, 8'd211, 8'd212, 8'd213, 8'd214, 8'd215,
        8'd216, 8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223,
        8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231,
        8'd232, 8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239,
        8'd240, 8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247,
        8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255
    };

endpackage

@@ rtl/zero_suppressed_pixel_word_decoder.sv @@
// Top level of the zero-suppressed pixel word decoder.
// Throughput: one word per cycle while the output is not stalled; input register, then
// decode and table lookup into the output register. Words that give no hit are absorbed
// in the decode stage.
// Reset (synchronous, active low): row base, common mode and skip flag cleared,
// first-hit flag armed, row limit 960, both pipeline stages empty.
module zero_suppressed_pixel_word_decoder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  zspwd_pkg::t_word       i_word,
    input  logic                   i_event_start,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  zspwd_pkg::t_row_limit  i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output zspwd_pkg::t_row        o_row,
    output zspwd_pkg::t_col        o_col,
    output zspwd_pkg::t_value      o_value,
    output zspwd_pkg::t_cm         o_common_mode,
    output logic                   o_first_hit,
    output zspwd_pkg::t_gate       o_start_gate,
    output logic                   o_out_of_range
);
    import zspwd_pkg::*;

    t_row_limit r_row_limit;

    logic       r_s1_valid;
    t_word      r_word;
    logic       r_evs;

    logic [8:0] r_row_hi;
    t_cm        r_cm;
    logic       r_skip;
    logic       r_first;

    logic       r_out_valid;
    t_row       r_row;
    t_col       r_col;
    t_value     r_value;
    t_cm        r_out_cm;
    logic       r_first_hit;
    t_gate      r_gate;
    logic       r_oor;

    logic [8:0] eff_row_hi;
    t_cm        eff_cm;
    logic       eff_skip;
    logic       eff_first;
    logic       is_sub;
    logic       is_hdr;
    logic       is_hit;
    logic       out_ready;
    logic       s1_move;
    logic       in_take;
    t_drain     drain;
    t_row       mrow;

    always_comb begin
        eff_row_hi = r_evs ? '0 : r_row_hi;
        eff_cm     = r_evs ? '0 : r_cm;
        eff_skip   = r_evs ? 1'b0 : r_skip;
        eff_first  = r_evs ? 1'b1 : r_first;
        is_sub     = !eff_skip && (r_word == SUBFRAME_WORD);
        is_hdr     = !eff_skip && !is_sub && !r_word[15];
        is_hit     = !eff_skip && !is_sub && r_word[15];
        drain      = DRAIN_MAP[{r_word[13:8], eff_row_hi[0], r_word[14]}];
        mrow       = {eff_row_hi[8:1], ~drain[1:0]};
    end

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign s1_move     = r_s1_valid && (!is_hit || out_ready);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_s1_valid && !s1_move;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_limit <= ROW_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_row_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_word;
            r_evs  <= i_event_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_hi <= '0;
            r_cm     <= '0;
            r_skip   <= 1'b0;
            r_first  <= 1'b1;
        end else if (s1_move) begin
            r_row_hi <= is_hdr ? r_word[14:6] : eff_row_hi;
            r_cm     <= is_hdr ? r_word[5:0] : eff_cm;
            r_skip   <= is_sub;
            r_first  <= is_hit ? 1'b0 : eff_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && is_hit) begin
            r_out_valid <= 1'b1;
        end else if (out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && is_hit) begin
            r_row       <= mrow;
            r_col       <= drain[7:2];
            r_value     <= r_word[7:0];
            r_out_cm    <= eff_cm;
            r_first_hit <= eff_first;
            r_gate      <= eff_first ? mrow[9:2] : '0;
            r_oor       <= ({1'b0, mrow} >= r_row_limit);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row          = r_row;
    assign o_col          = r_col;
    assign o_value        = r_value;
    assign o_common_mode  = r_out_cm;
    assign o_first_hit    = r_first_hit;
    assign o_start_gate   = r_gate;
    assign o_out_of_range = r_oor;

endmodule

@@ rtl/zspwd_checker.sv @@
// Port-level checker of the pixel word decoder, bound to the top level.
`include "assert_macros.svh"

module zspwd_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  zspwd_pkg::t_word       i_word,
    input  logic                   i_event_start,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  zspwd_pkg::t_row        o_row,
    input  zspwd_pkg::t_col        o_col,
    input  zspwd_pkg::t_value      o_value,
    input  zspwd_pkg::t_cm         o_common_mode,
    input  logic                   o_first_hit,
    input  zspwd_pkg::t_gate       o_start_gate,
    input  logic                   o_out_of_range
);

    `ZS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_word) && $stable(i_event_start), "stalled input changed")
    `ZS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_row) && $stable(o_col) && $stable(o_value)
        && $stable(o_common_mode) && $stable(o_first_hit) && $stable(o_start_gate)
        && $stable(o_out_of_range), "stalled transaction changed")
    `ZS_ASSERT_ALWAYS(a_gate_first, i_clk, i_rst_n,
        !(o_out_valid && o_first_hit) || (o_start_gate == o_row[9:2]),
        "start gate does not match first hit row")
    `ZS_ASSERT_ALWAYS(a_gate_zero, i_clk, i_rst_n,
        !(o_out_valid && !o_first_hit) || (o_start_gate == '0),
        "start gate set on a later hit")
    `ZS_ASSERT_NEXT_RST(a_rst_empty, i_clk, !i_rst_n, !o_out_valid,
        "output valid after reset")

endmodule

bind zero_suppressed_pixel_word_decoder zspwd_checker u_zspwd_checker (.*);
